### hw/rtl/node_lifecycle_tracker_assert.svh
// Assertion macros for the node lifecycle tracker.
`ifndef NODE_LIFECYCLE_TRACKER_ASSERT_SVH
`define NODE_LIFECYCLE_TRACKER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define NLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("node_lifecycle_tracker: assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define NLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("node_lifecycle_tracker: assertion failed");

`endif

### hw/rtl/nlt_pkg.sv
// Shared types and constants of the node lifecycle tracker.
package nlt_pkg;

    localparam int NODE_COUNT = 6;
    localparam int SLOT_W     = 3;
    localparam int ID_W       = 8;
    localparam int TABLE_W    = 64;

    typedef enum logic [1:0] {
        FUNC_HB     = 2'd0,
        FUNC_SYNC   = 2'd1,
        FUNC_RESET  = 2'd2,
        FUNC_UNUSED = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        NMT_INIT  = 3'd0,
        NMT_PREOP = 3'd1,
        NMT_OP    = 3'd2,
        NMT_STOP  = 3'd3
    } t_nmt;

    typedef enum logic [1:0] {
        HB_UNCONF  = 2'd0,
        HB_UNKNOWN = 2'd1,
        HB_ACTIVE  = 2'd2,
        HB_TIMEOUT = 2'd3
    } t_hb;

    typedef enum logic [2:0] {
        ST_UNINIT      = 3'd0,
        ST_PROCESSING  = 3'd1,
        ST_INITIALIZED = 3'd2,
        ST_OPERATIONAL = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_STOPPED     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_PREOP = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_OP    = 2'd2
    } t_cmd;

    // Write request from the event logic into the slot store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        t_status           status;
        logic              power;
    } t_slot_wr;

    // Decision of the event logic for one item
    typedef struct packed {
        t_status status;
        logic    power;
        logic    cmd_valid;
        t_cmd    cmd;
        logic    motion_reset;
    } t_evt_res;

    // Release rule: initialized or stopped go to released, processing to uninit
    function automatic t_status release_rule(input t_status s);
        t_status r;
        r = s;
        if (s == ST_INITIALIZED || s == ST_STOPPED) begin
            r = ST_RELEASED;
        end else if (s == ST_PROCESSING) begin
            r = ST_UNINIT;
        end
        return r;
    endfunction

endpackage

### hw/rtl/nlt_if.sv
// Valid/ready channel interfaces for events and results.
interface nlt_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] node_id;
    logic [2:0] slot_index;
    logic [2:0] nmt_state;
    logic [1:0] heartbeat_state;

    modport source (output valid, func, node_id, slot_index, nmt_state, heartbeat_state,
                    input ready);
    modport sink   (input valid, func, node_id, slot_index, nmt_state, heartbeat_state,
                    output ready);
endinterface

interface nlt_res_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       command_valid;
    logic [1:0] command_code;
    logic       motion_reset;
    logic [2:0] slot_status;
    logic       power_enabled;

    modport source (output valid, accepted, command_valid, command_code, motion_reset,
                    slot_status, power_enabled, input ready);
    modport sink   (input valid, accepted, command_valid, command_code, motion_reset,
                    slot_status, power_enabled, output ready);
endinterface

### hw/rtl/nlt_slot_store.sv
// Per-slot status and power mark registers with one read and one write port.
module nlt_slot_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [nlt_pkg::SLOT_W-1:0]     i_rd_idx,
    output nlt_pkg::t_status               o_rd_status,
    output logic                           o_rd_power,
    input  nlt_pkg::t_slot_wr              i_wr
);

    nlt_pkg::t_status r_status [nlt_pkg::NODE_COUNT];
    logic             r_power  [nlt_pkg::NODE_COUNT];

    // Update one slot; reset clears every slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < nlt_pkg::NODE_COUNT; k++) begin
                r_status[k] <= nlt_pkg::ST_UNINIT;
                r_power[k]  <= 1'b0;
            end
        end else if (i_wr.en) begin
            r_status[i_wr.idx] <= i_wr.status;
            r_power[i_wr.idx]  <= i_wr.power;
        end
    end

    // Read the slot; an out-of-range slot reads as zero
    always_comb begin
        o_rd_status = nlt_pkg::ST_UNINIT;
        o_rd_power  = 1'b0;
        if (32'(i_rd_idx) < nlt_pkg::NODE_COUNT) begin
            o_rd_status = r_status[i_rd_idx];
            o_rd_power  = r_power[i_rd_idx];
        end
    end

endmodule

### hw/rtl/nlt_event_logic.sv
// Status transition and command decision for one event.
module nlt_event_logic (
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_nmt_state,
    input  logic [1:0]         i_heartbeat_state,
    input  nlt_pkg::t_status   i_status,
    input  logic               i_power,
    output nlt_pkg::t_evt_res  o_res
);

    always_comb begin
        o_res.status       = i_status;
        o_res.power        = i_power;
        o_res.cmd_valid    = 1'b0;
        o_res.cmd          = nlt_pkg::CMD_PREOP;
        o_res.motion_reset = 1'b0;
        case (nlt_pkg::t_func'(i_func))
            nlt_pkg::FUNC_HB: begin
                // Lost heartbeat releases the slot ahead of any NMT state
                if (nlt_pkg::t_hb'(i_heartbeat_state) == nlt_pkg::HB_TIMEOUT ||
                    nlt_pkg::t_hb'(i_heartbeat_state) == nlt_pkg::HB_UNKNOWN) begin
                    o_res.status       = nlt_pkg::release_rule(i_status);
                    o_res.motion_reset = 1'b1;
                end else begin
                    case (nlt_pkg::t_nmt'(i_nmt_state))
                        nlt_pkg::NMT_INIT: begin
                            o_res.status    = nlt_pkg::ST_UNINIT;
                            o_res.cmd_valid = 1'b1;
                            o_res.cmd       = nlt_pkg::CMD_PREOP;
                        end
                        nlt_pkg::NMT_PREOP: begin
                            o_res.status    = nlt_pkg::release_rule(i_status);
                            o_res.cmd_valid = 1'b1;
                            o_res.cmd       = nlt_pkg::CMD_QUERY;
                        end
                        nlt_pkg::NMT_OP: begin
                            if (i_status == nlt_pkg::ST_INITIALIZED) begin
                                o_res.power = 1'b1;
                            end else begin
                                o_res.cmd_valid = 1'b1;
                                o_res.cmd       = nlt_pkg::CMD_QUERY;
                            end
                        end
                        nlt_pkg::NMT_STOP: begin
                            if (i_status == nlt_pkg::ST_INITIALIZED ||
                                i_status == nlt_pkg::ST_RELEASED) begin
                                o_res.status = nlt_pkg::ST_STOPPED;
                            end else begin
                                o_res.status = nlt_pkg::ST_UNINIT;
                            end
                        end
                        default: begin
                            // other NMT states leave the slot alone
                        end
                    endcase
                end
            end
            nlt_pkg::FUNC_SYNC: begin
                o_res.status = nlt_pkg::ST_INITIALIZED;
                if (nlt_pkg::t_nmt'(i_nmt_state) == nlt_pkg::NMT_OP) begin
                    o_res.power = 1'b1;
                end else begin
                    o_res.cmd_valid = 1'b1;
                    o_res.cmd       = nlt_pkg::CMD_OP;
                end
            end
            nlt_pkg::FUNC_RESET: begin
                o_res.status       = nlt_pkg::ST_UNINIT;
                o_res.motion_reset = 1'b1;
            end
            default: begin
                // unused code: never accepted upstream
            end
        endcase
    end

endmodule

### hw/rtl/node_lifecycle_tracker.sv
// Top level of the node lifecycle tracker.
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+---------------------------------------------
//  i_evt      | in  | valid / ready  | func, node_id, slot_index, nmt_state, heartbeat_state
//  o_res      | out | valid / ready  | accepted, command, motion reset, status, power mark
//  i_cfg_*    | in  | write enable   | node id table, 64 bits
//
// One item per cycle while the output is not stalled; an accepted item passes the
// input register, then a read-modify-write of the slot registers that lands in the
// result register.
// Synchronous reset clears control and all slot status and power marks at once.
// A stalled result holds in the result register while the input register still
// takes one more item; the input side stalls only when both are full.
`include "node_lifecycle_tracker_assert.svh"

module node_lifecycle_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nlt_pkg::TABLE_W-1:0]    i_cfg_wdata,
    nlt_evt_if.sink                        i_evt,
    nlt_res_if.source                      o_res
);

    logic [nlt_pkg::TABLE_W-1:0] r_node_id_table;

    logic                         r_in_valid, n_in_valid;
    logic [1:0]                   r_func;
    logic [nlt_pkg::ID_W-1:0]     r_node_id;
    logic [nlt_pkg::SLOT_W-1:0]   r_slot;
    logic [2:0]                   r_nmt;
    logic [1:0]                   r_hb;

    logic                         r_res_valid, n_res_valid;
    logic                         r_accepted;
    logic                         r_cmd_valid;
    logic [1:0]                   r_cmd_code;
    logic                         r_motion_reset;
    logic [2:0]                   r_slot_status;
    logic                         r_power;

    logic                         in_fire;
    logic                         advance;
    logic                         in_range;
    logic                         acc;
    logic [nlt_pkg::ID_W-1:0]     stored_id;
    nlt_pkg::t_status             rd_status;
    logic                         rd_power;
    nlt_pkg::t_evt_res            evt_res;
    nlt_pkg::t_slot_wr            slot_wr;

    // Handshake and stage movement
    assign advance     = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign in_fire     = i_evt.valid && i_evt.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_res_valid = r_res_valid;
        if (advance) begin
            n_res_valid = 1'b1;
        end else if (o_res.ready) begin
            n_res_valid = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_res_valid     <= 1'b0;
            r_node_id_table <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_node_id_table <= i_cfg_wdata;
            end
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func    <= i_evt.func;
            r_node_id <= i_evt.node_id;
            r_slot    <= i_evt.slot_index;
            r_nmt     <= i_evt.nmt_state;
            r_hb      <= i_evt.heartbeat_state;
        end
    end

    // Match the slot against its configured node id
    assign stored_id = r_node_id_table[{r_slot, 3'b000} +: nlt_pkg::ID_W];
    assign in_range  = 32'(r_slot) < nlt_pkg::NODE_COUNT;
    assign acc       = in_range && (stored_id == r_node_id) &&
                       (r_func != nlt_pkg::FUNC_UNUSED);

    nlt_slot_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx    (r_slot),
        .o_rd_status (rd_status),
        .o_rd_power  (rd_power),
        .i_wr        (slot_wr)
    );

    nlt_event_logic u_logic (
        .i_func            (r_func),
        .i_nmt_state       (r_nmt),
        .i_heartbeat_state (r_hb),
        .i_status          (rd_status),
        .i_power           (rd_power),
        .o_res             (evt_res)
    );

    // Write back only for accepted items
    always_comb begin
        slot_wr.en     = advance && acc;
        slot_wr.idx    = r_slot;
        slot_wr.status = evt_res.status;
        slot_wr.power  = evt_res.power;
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_accepted     <= acc;
            r_cmd_valid    <= acc && evt_res.cmd_valid;
            r_cmd_code     <= (acc && evt_res.cmd_valid) ? evt_res.cmd : nlt_pkg::CMD_PREOP;
            r_motion_reset <= acc && evt_res.motion_reset;
            r_slot_status  <= acc ? evt_res.status : rd_status;
            r_power        <= acc ? evt_res.power : rd_power;
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.accepted      = r_accepted;
    assign o_res.command_valid = r_cmd_valid;
    assign o_res.command_code  = r_cmd_code;
    assign o_res.motion_reset  = r_motion_reset;
    assign o_res.slot_status   = r_slot_status;
    assign o_res.power_enabled = r_power;

    // Checks
    `NLT_ASSERT_NEXT(a_in_captured, i_clk, i_rst_n, in_fire, r_in_valid)
    `NLT_ASSERT_NEXT(a_item_to_result, i_clk, i_rst_n, r_in_valid && !r_res_valid, r_res_valid)
    `NLT_ASSERT_NEXT(a_cfg_written, i_clk, i_rst_n, i_cfg_we, r_node_id_table == $past(i_cfg_wdata))
    `NLT_ASSERT_IMP(a_cmd_needs_accept, i_clk, i_rst_n, r_res_valid && r_cmd_valid, r_accepted)

endmodule

### sim/node_lifecycle_tracker_tb.sv
// Self-checking testbench of the node lifecycle tracker: directed walks and random events.
module node_lifecycle_tracker_tb;

    localparam logic [2:0] NMT_OTHER   = 3'd4;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         LONG_HOLD   = 60;

    typedef struct {
        logic [1:0] func;
        logic [7:0] node_id;
        logic [2:0] slot;
        logic [2:0] nmt;
        logic [1:0] hb;
    } t_evt;

    typedef struct {
        logic       accepted;
        logic       command_valid;
        logic [1:0] command_code;
        logic       motion_reset;
        logic [2:0] slot_status;
        logic       power_enabled;
    } t_res;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    nlt_evt_if evt_if ();
    nlt_res_if res_if ();

    node_lifecycle_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_evt       (evt_if),
        .o_res       (res_if)
    );

    // Own copy of the slot state and the node id table
    logic [63:0]      id_table_model;
    nlt_pkg::t_status status_model [0:7];
    logic             power_model  [0:7];

    t_res slot_reports_due [$];

    int sender_gap_pct;
    int sink_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int stall_left;
    int quiet_cycles;
    int mismatches;
    int items_sent;
    int items_taken;
    int reports_checked;
    int tables_loaded;

    // Clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Release rule of a slot that lost its node
    function automatic nlt_pkg::t_status dropped_status(input nlt_pkg::t_status s);
        if (s == nlt_pkg::ST_INITIALIZED || s == nlt_pkg::ST_STOPPED) begin
            return nlt_pkg::ST_RELEASED;
        end else if (s == nlt_pkg::ST_PROCESSING) begin
            return nlt_pkg::ST_UNINIT;
        end
        return s;
    endfunction

    // Apply one event to the slot state and return the report it causes
    function automatic t_res track_slot_event(input t_evt it);
        t_res             r;
        nlt_pkg::t_status s;
        logic             p;
        logic [7:0]       stored;
        r = '{default: '0};
        if (it.slot < nlt_pkg::NODE_COUNT) begin
            stored     = id_table_model[8*it.slot +: 8];
            r.accepted = (stored == it.node_id) && (it.func != nlt_pkg::FUNC_UNUSED);
        end
        if (r.accepted) begin
            s = status_model[it.slot];
            p = power_model[it.slot];
            if (it.func == nlt_pkg::FUNC_HB) begin
                if (it.hb == nlt_pkg::HB_TIMEOUT || it.hb == nlt_pkg::HB_UNKNOWN) begin
                    s              = dropped_status(s);
                    r.motion_reset = 1'b1;
                end else begin
                    case (it.nmt)
                        nlt_pkg::NMT_INIT: begin
                            s               = nlt_pkg::ST_UNINIT;
                            r.command_valid = 1'b1;
                            r.command_code  = nlt_pkg::CMD_PREOP;
                        end
                        nlt_pkg::NMT_PREOP: begin
                            s               = dropped_status(s);
                            r.command_valid = 1'b1;
                            r.command_code  = nlt_pkg::CMD_QUERY;
                        end
                        nlt_pkg::NMT_OP: begin
                            if (s != nlt_pkg::ST_INITIALIZED) begin
                                r.command_valid = 1'b1;
                                r.command_code  = nlt_pkg::CMD_QUERY;
                            end else begin
                                p = 1'b1;
                            end
                        end
                        nlt_pkg::NMT_STOP: begin
                            s = (s == nlt_pkg::ST_INITIALIZED || s == nlt_pkg::ST_RELEASED)
                                ? nlt_pkg::ST_STOPPED : nlt_pkg::ST_UNINIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (it.func == nlt_pkg::FUNC_SYNC) begin
                s = nlt_pkg::ST_INITIALIZED;
                if (it.nmt != nlt_pkg::NMT_OP) begin
                    r.command_valid = 1'b1;
                    r.command_code  = nlt_pkg::CMD_OP;
                end else begin
                    p = 1'b1;
                end
            end else begin
                s              = nlt_pkg::ST_UNINIT;
                r.motion_reset = 1'b1;
            end
            status_model[it.slot] = s;
            power_model[it.slot]  = p;
        end
        if (it.slot < nlt_pkg::NODE_COUNT) begin
            r.slot_status   = status_model[it.slot];
            r.power_enabled = power_model[it.slot];
        end
        return r;
    endfunction

    function automatic t_evt pack_item(input logic [1:0] func, input logic [7:0] node_id,
                                       input logic [2:0] slot, input logic [2:0] nmt,
                                       input logic [1:0] hb);
        t_evt it;
        it.func    = func;
        it.node_id = node_id;
        it.slot    = slot;
        it.nmt     = nmt;
        it.hb      = hb;
        return it;
    endfunction

    function automatic logic [7:0] slot_id(input int slot);
        return id_table_model[8*slot +: 8];
    endfunction

    // Heartbeat value that does not drop the node
    function automatic logic [1:0] live_hb();
        return $urandom_range(0, 1) ? nlt_pkg::HB_ACTIVE : nlt_pkg::HB_UNCONF;
    endfunction

    // Random event, mostly aimed at a configured slot with its own id
    function automatic t_evt random_item();
        t_evt it;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            it.slot = 3'($urandom_range(6, 7));
        end else begin
            it.slot = 3'($urandom_range(0, nlt_pkg::NODE_COUNT - 1));
        end
        if (it.slot < nlt_pkg::NODE_COUNT && $urandom_range(0, 9) != 0) begin
            it.node_id = slot_id(it.slot);
        end else begin
            it.node_id = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            it.func = nlt_pkg::FUNC_HB;
        end else if (pick < 14) begin
            it.func = nlt_pkg::FUNC_SYNC;
        end else if (pick < 18) begin
            it.func = nlt_pkg::FUNC_RESET;
        end else begin
            it.func = nlt_pkg::FUNC_UNUSED;
        end
        it.nmt = 3'($urandom_range(0, 4));
        it.hb  = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : live_hb();
        return it;
    endfunction

    // Offer one item, with an optional gap before it, and hold it until taken
    task automatic send_item(input t_evt it);
        t_res due;
        if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        evt_if.valid           <= 1'b1;
        evt_if.func            <= it.func;
        evt_if.node_id         <= it.node_id;
        evt_if.slot_index      <= it.slot;
        evt_if.nmt_state       <= it.nmt;
        evt_if.heartbeat_state <= it.hb;
        do @(posedge clk); while (evt_if.ready !== 1'b1);
        due = track_slot_event(it);
        slot_reports_due.push_back(due);
        items_sent++;
        if (due.accepted) begin
            items_taken++;
        end
    endtask

    // Drop valid, let the block drain, then load the id table
    task automatic load_id_table(input logic [63:0] ids);
        evt_if.valid <= 1'b0;
        while (slot_reports_due.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ids;
        @(posedge clk);
        cfg_we         <= 1'b0;
        id_table_model  = ids;
        tables_loaded++;
    endtask

    // Table as it comes out of reset: every slot holds id zero
    task automatic test_reset_state();
        sender_gap_pct = 20;
        sink_stall_pct = 20;
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h00, 3'd0, NMT_OTHER, nlt_pkg::HB_UNCONF));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h00, 3'd7, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_ACTIVE));
    endtask

    // Every event kind, heartbeat state and NMT state on known slots
    task automatic test_directed();
        load_id_table(64'h0000_FF5A_A533_0100);
        send_item(pack_item(nlt_pkg::FUNC_RESET, 8'h00, 3'd0, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_PREOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_SYNC, 8'h01, 3'd1, nlt_pkg::NMT_PREOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_STOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_UNKNOWN));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_STOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_TIMEOUT));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h01, 3'd1, NMT_OTHER, nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_SYNC, 8'hFF, 3'd5, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_UNCONF));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hFF, 3'd5, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_TIMEOUT));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hFF, 3'd5, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hFF, 3'd5, nlt_pkg::NMT_STOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hFF, 3'd5, nlt_pkg::NMT_PREOP,
                            nlt_pkg::HB_UNCONF));
        // Unused event kind, wrong id, slots past the node count
        send_item(pack_item(nlt_pkg::FUNC_UNUSED, 8'h33, 3'd2, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_SYNC, 8'h34, 3'd2, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_RESET, 8'h00, 3'd6, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h00, 3'd7, nlt_pkg::NMT_OP,
                            nlt_pkg::HB_TIMEOUT));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hA5, 3'd3, nlt_pkg::NMT_INIT,
                            nlt_pkg::HB_UNCONF));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'hA5, 3'd3, nlt_pkg::NMT_STOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_SYNC, 8'h5A, 3'd4, nlt_pkg::NMT_STOP,
                            nlt_pkg::HB_ACTIVE));
        send_item(pack_item(nlt_pkg::FUNC_HB, 8'h5A, 3'd4, nlt_pkg::NMT_PREOP,
                            nlt_pkg::HB_ACTIVE));
    endtask

    // Boot, sync, run, stop and lose a node, with random stray events between
    task automatic test_lifecycles(input int walks);
        int         slot;
        logic [7:0] id;
        load_id_table({$urandom, $urandom});
        sender_gap_pct = 15;
        sink_stall_pct = 15;
        repeat (walks) begin
            slot = $urandom_range(0, nlt_pkg::NODE_COUNT - 1);
            id   = slot_id(slot);
            send_item(pack_item(nlt_pkg::FUNC_RESET, id, 3'(slot), 3'($urandom_range(0, 4)),
                                live_hb()));
            send_item(pack_item(nlt_pkg::FUNC_HB, id, 3'(slot), nlt_pkg::NMT_INIT, live_hb()));
            send_item(pack_item(nlt_pkg::FUNC_HB, id, 3'(slot), nlt_pkg::NMT_PREOP, live_hb()));
            send_item(pack_item(nlt_pkg::FUNC_SYNC, id, 3'(slot), 3'($urandom_range(0, 4)),
                                live_hb()));
            send_item(pack_item(nlt_pkg::FUNC_HB, id, 3'(slot), nlt_pkg::NMT_OP, live_hb()));
            if ($urandom_range(0, 1) == 0) begin
                send_item(random_item());
            end
            send_item(pack_item(nlt_pkg::FUNC_HB, id, 3'(slot), nlt_pkg::NMT_STOP, live_hb()));
            send_item(pack_item(nlt_pkg::FUNC_HB, id, 3'(slot), 3'($urandom_range(0, 4)),
                                $urandom_range(0, 1) ? nlt_pkg::HB_TIMEOUT
                                                     : nlt_pkg::HB_UNKNOWN));
        end
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count) begin
            send_item(random_item());
        end
    endtask

    // Hold the output for a long stretch while events keep coming
    task automatic test_backpressure(input int count);
        load_id_table({$urandom, $urandom});
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (count) begin
            send_item(random_item());
        end
    endtask

    // Output ready: long holds on request, short random stalls otherwise
    always @(posedge clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left = $urandom_range(1, 8) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    function void check_field(input string field, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Compare each report with the oldest one due
    always @(posedge clk) begin
        t_res want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (slot_reports_due.size() == 0) begin
                $error("report with no event outstanding");
                mismatches++;
            end else begin
                want = slot_reports_due.pop_front();
                check_field("accepted",      want.accepted,      res_if.accepted);
                check_field("command_valid", want.command_valid, res_if.command_valid);
                check_field("command_code",  want.command_code,  res_if.command_code);
                check_field("motion_reset",  want.motion_reset,  res_if.motion_reset);
                check_field("slot_status",   want.slot_status,   res_if.slot_status);
                check_field("power_enabled", want.power_enabled, res_if.power_enabled);
                reports_checked++;
            end
        end
    end

    // Stop a run in which nothing moves on either side
    always @(posedge clk) begin
        if ((evt_if.valid === 1'b1 && evt_if.ready === 1'b1)
            || (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        evt_if.valid           = 1'b0;
        evt_if.func            = '0;
        evt_if.node_id         = '0;
        evt_if.slot_index      = '0;
        evt_if.nmt_state       = '0;
        evt_if.heartbeat_state = '0;
        id_table_model         = '0;
        for (int i = 0; i < 8; i++) begin
            status_model[i] = nlt_pkg::ST_UNINIT;
            power_model[i]  = 1'b0;
        end
        sender_gap_pct  = 0;
        sink_stall_pct  = 0;
        hold_requests   = 0;
        items_sent      = 0;
        items_taken     = 0;
        tables_loaded   = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_lifecycles(20);
        load_id_table({$urandom, $urandom});
        test_random_traffic(220, 30, 30);
        load_id_table({64{1'b1}});
        test_random_traffic(150, 10, 40);
        load_id_table(64'h0);
        test_random_traffic(150, 40, 10);
        test_backpressure(30);
        load_id_table({$urandom, $urandom});
        test_random_traffic(100, 25, 25);
        // Last stretch at full rate on both sides
        test_random_traffic(150, 0, 0);

        evt_if.valid <= 1'b0;
        while (slot_reports_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d reports for %0d events, %0d of them taken by their slot.",
                 reports_checked, items_sent, items_taken);
        $display("Ran %0d id tables, lifecycle walks, two-sided stalls and a long output hold.",
                 tables_loaded);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
